// ===== src/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue: command and status
// codes, sequencer states and the request/result bundles between modules.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int CNT_W  = 7;
    localparam int CMD_W  = 3;
    localparam int STS_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ       = 3'd4,
        CMD_FIND       = 3'd5
    } cmd_t;

    typedef enum logic [STS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_FIND,
        S_RESP
    } state_t;

    typedef struct packed {
        logic               start;
        cmd_t               cmd;
        logic [DATA_W-1:0]  data;
        logic [POS_W-1:0]   pos;
    } request_t;

    typedef struct packed {
        logic               valid;
        logic [DATA_W-1:0]  value;
        logic [POS_W-1:0]   found;
        status_t            status;
        logic [CNT_W-1:0]   count;
    } result_t;

endpackage

// ===== src/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed values in a circular slot store.
// ----------------------------------------------------------------------------
// One command is worked on at a time; s_tready is high only while the
// sequencer is idle. Pushes, unknown commands and failed pops or reads go
// from S_EXEC straight to S_RESP, pops and reads that return a value pass
// through S_RDWAIT first, and a find stays in S_FIND for each stored entry
// it compares (up to the element count). The find length is set by the
// single read port of the slot memory, scanned one entry per cycle through
// one comparator. Each result goes to an output register, so a new command
// is accepted while the previous result still waits for m_tready. The slot
// store needs no clearing after reset.
module double_ended_queue #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_value[31:0], position[38:32], pad[39]
    input  logic [2:0]  s_tuser,   // command[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // result_value[31:0], found_position[38:32],
                                   // status[40:39], element_count[47:41]
);

    dq_pkg::request_t req;
    dq_pkg::result_t  res;
    logic             ready;
    logic             out_free;

    logic                     mem_we;
    logic [$clog2(DEPTH)-1:0] mem_waddr;
    logic [VALUE_WIDTH-1:0]   mem_wdata;
    logic                     mem_re;
    logic [$clog2(DEPTH)-1:0] mem_raddr;
    logic [VALUE_WIDTH-1:0]   mem_rdata;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [47:0] m_tdata_reg;

    assign s_tready  = ready;
    assign req.start = s_tvalid && ready;
    assign req.cmd   = dq_pkg::cmd_t'(s_tuser);
    assign req.data  = s_tdata[31:0];
    assign req.pos   = s_tdata[38:32];

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res.valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_tdata_reg <= {res.count, res.status, res.found, res.value};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    dq_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .ready     (ready),
        .out_free  (out_free),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    dq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule

// ===== src/dq_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_mem
// Slot storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dq_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/dq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl
// Command sequencer: front pointer and count, one shared slot address adder
// with wrap, and a single compare unit that the find scan steps through.
// ----------------------------------------------------------------------------
module dq_ctrl #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dq_pkg::request_t         req,
    output logic                     ready,
    input  logic                     out_free,
    output dq_pkg::result_t          res,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output logic [VALUE_WIDTH-1:0]   mem_wdata,
    output logic                     mem_re,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    input  logic [VALUE_WIDTH-1:0]   mem_rdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > dq_pkg::POS_W) ? CW : dq_pkg::POS_W;
    localparam int SW = PW + 1;

    dq_pkg::state_t  state_reg, state_next;
    dq_pkg::cmd_t    cmd_reg;
    dq_pkg::status_t status_reg, status_next;

    logic [PW-1:0]             front_reg, front_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [PW-1:0]             chk_reg, chk_next;
    logic [CW-1:0]             found_reg, found_next;
    logic [dq_pkg::DATA_W-1:0] value_reg, value_next;
    logic [VALUE_WIDTH-1:0]    key_reg;
    logic [dq_pkg::POS_W-1:0]  pos_reg;

    logic [VALUE_WIDTH-1:0]    key_in;
    logic [dq_pkg::DATA_W-1:0] rd_sext;
    logic [PW-1:0]             offset;
    logic [SW-1:0]             sum;
    logic [SW-1:0]             sum_wrap;
    logic [PW-1:0]             addr_wrap;
    logic [dq_pkg::POS_W-1:0]  pos_fix;
    logic [LW-1:0]             pos_ext;
    logic [LW-1:0]             count_ext;
    logic [LW-1:0]             found_ext;
    logic [LW-1:0]             pos_m1;
    logic [CW-1:0]             count_m1;
    logic [CW-1:0]             chk_p1;
    logic                      is_full;
    logic                      is_empty;
    logic                      res_valid;

    generate
        if (VALUE_WIDTH >= dq_pkg::DATA_W) begin : g_wide
            assign key_in  = VALUE_WIDTH'(req.data);
            assign rd_sext = mem_rdata[dq_pkg::DATA_W-1:0];
        end else begin : g_narrow
            assign key_in  = req.data[VALUE_WIDTH-1:0];
            assign rd_sext = {{(dq_pkg::DATA_W-VALUE_WIDTH){mem_rdata[VALUE_WIDTH-1]}},
                              mem_rdata};
        end
    endgenerate

    // shared slot address unit: front + offset, modulo DEPTH
    assign sum       = {1'b0, front_reg} + {1'b0, offset};
    assign sum_wrap  = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
    assign addr_wrap = sum_wrap[PW-1:0];

    assign pos_fix   = (pos_reg == '0) ? dq_pkg::POS_W'(1) : pos_reg;
    assign pos_ext   = LW'(pos_fix);
    assign pos_m1    = pos_ext - LW'(1);
    assign count_ext = LW'(count_reg);
    assign found_ext = LW'(found_reg);
    assign count_m1  = count_reg - CW'(1);
    assign chk_p1    = CW'(chk_reg) + CW'(1);
    assign is_full   = (count_reg >= CW'(DEPTH));
    assign is_empty  = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dq_pkg::S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cmd_reg <= req.cmd;
            key_reg <= key_in;
            pos_reg <= req.pos;
        end
        chk_reg    <= chk_next;
        found_reg  <= found_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    always_comb begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        chk_next    = chk_reg;
        found_next  = found_reg;
        value_next  = value_reg;
        status_next = status_reg;
        offset      = '0;
        mem_we      = 1'b0;
        mem_waddr   = addr_wrap;
        mem_wdata   = key_reg;
        mem_re      = 1'b0;
        mem_raddr   = addr_wrap;
        ready       = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            dq_pkg::S_IDLE: begin
                ready = 1'b1;
                if (req.start) begin
                    state_next = dq_pkg::S_EXEC;
                end
            end
            dq_pkg::S_EXEC: begin
                value_next  = '0;
                found_next  = '0;
                status_next = dq_pkg::ST_OK;
                state_next  = dq_pkg::S_RESP;
                case (cmd_reg)
                    dq_pkg::CMD_PUSH_BACK: begin
                        offset = count_reg[PW-1:0];
                        if (is_full) begin
                            status_next = dq_pkg::ST_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    dq_pkg::CMD_PUSH_FRONT: begin
                        offset = PW'(DEPTH - 1);
                        if (is_full) begin
                            status_next = dq_pkg::ST_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            front_next = addr_wrap;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    dq_pkg::CMD_POP_BACK: begin
                        offset = count_m1[PW-1:0];
                        if (is_empty) begin
                            status_next = dq_pkg::ST_EMPTY;
                        end else begin
                            mem_re     = 1'b1;
                            count_next = count_m1;
                            state_next = dq_pkg::S_RDWAIT;
                        end
                    end
                    dq_pkg::CMD_POP_FRONT: begin
                        offset    = PW'(1);
                        mem_raddr = front_reg;
                        if (is_empty) begin
                            status_next = dq_pkg::ST_EMPTY;
                        end else begin
                            mem_re     = 1'b1;
                            front_next = addr_wrap;
                            count_next = count_m1;
                            state_next = dq_pkg::S_RDWAIT;
                        end
                    end
                    dq_pkg::CMD_READ: begin
                        offset = pos_m1[PW-1:0];
                        if (is_empty) begin
                            status_next = dq_pkg::ST_EMPTY;
                        end else if (pos_ext > count_ext) begin
                            status_next = dq_pkg::ST_RANGE;
                        end else begin
                            mem_re     = 1'b1;
                            state_next = dq_pkg::S_RDWAIT;
                        end
                    end
                    dq_pkg::CMD_FIND: begin
                        if (!is_empty) begin
                            mem_re     = 1'b1;
                            chk_next   = '0;
                            state_next = dq_pkg::S_FIND;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            dq_pkg::S_RDWAIT: begin
                value_next = rd_sext;
                state_next = dq_pkg::S_RESP;
            end
            dq_pkg::S_FIND: begin
                offset = chk_p1[PW-1:0];
                if (mem_rdata == key_reg) begin
                    found_next = chk_p1;
                    state_next = dq_pkg::S_RESP;
                end else if (chk_p1 == count_reg) begin
                    state_next = dq_pkg::S_RESP;
                end else begin
                    mem_re   = 1'b1;
                    chk_next = chk_p1[PW-1:0];
                end
            end
            dq_pkg::S_RESP: begin
                res_valid = out_free;
                if (out_free) begin
                    state_next = dq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = dq_pkg::S_IDLE;
            end
        endcase
    end

    assign res.valid  = res_valid;
    assign res.value  = value_reg;
    assign res.found  = found_ext[dq_pkg::POS_W-1:0];
    assign res.status = status_reg;
    assign res.count  = count_ext[dq_pkg::CNT_W-1:0];

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    a_front_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        front_reg < PW'(DEPTH - 1) || front_reg == PW'(DEPTH - 1))
        else $error("front pointer out of range");

    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !is_full)
        else $error("slot write while full");

    a_res_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> out_free)
        else $error("result issued with output register occupied");

    a_start_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> state_reg == dq_pkg::S_EXEC)
        else $error("accepted transaction not dispatched");

endmodule

// ===== dv/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the bounded double-ended queue. Commands are sent
// on the input stream and mirrored in a deque model that predicts value,
// found position, status and element count for each transaction. Results
// are compared field by field in order. A directed opening covers the empty,
// range, unknown and search cases. Random phases with varying push bias
// then drive the queue between empty and full, with random idling on both
// sides, one long output stall and one full drain pause.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;

    localparam int DQ_DEPTH   = 64;
    localparam int IX_W       = $clog2(DQ_DEPTH);
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [dq_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [dq_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic [dq_pkg::DATA_W-1:0] value;
        logic [dq_pkg::POS_W-1:0]  found;
        dq_pkg::status_t           status;
        logic [dq_pkg::CNT_W-1:0]  count;
    } dq_outcome_t;

    class deque_mirror;
        logic [dq_pkg::DATA_W-1:0] slots [DQ_DEPTH];
        int unsigned               head;
        int unsigned               fill;
        dq_outcome_t               pending [$];
        int unsigned               mismatches;

        function new();
            head       = 0;
            fill       = 0;
            mismatches = 0;
        endfunction

        function logic [IX_W-1:0] slot_ix(int unsigned n);
            return IX_W'(n % DQ_DEPTH);
        endfunction

        function logic [dq_pkg::DATA_W-1:0] stored_value();
            if (fill == 0)
                return $urandom;
            return slots[slot_ix(head + $urandom_range(fill - 1))];
        endfunction

        function void note_command(logic [dq_pkg::CMD_W-1:0] cmd,
                                   logic [dq_pkg::DATA_W-1:0] value,
                                   logic [dq_pkg::POS_W-1:0] pos);
            dq_outcome_t o;
            int unsigned p;
            o.value  = '0;
            o.found  = '0;
            o.status = dq_pkg::ST_OK;
            case (cmd)
                dq_pkg::CMD_PUSH_BACK: begin
                    if (fill == DQ_DEPTH) begin
                        o.status = dq_pkg::ST_FULL;
                    end else begin
                        slots[slot_ix(head + fill)] = value;
                        fill++;
                    end
                end
                dq_pkg::CMD_PUSH_FRONT: begin
                    if (fill == DQ_DEPTH) begin
                        o.status = dq_pkg::ST_FULL;
                    end else begin
                        head = (head + DQ_DEPTH - 1) % DQ_DEPTH;
                        slots[slot_ix(head)] = value;
                        fill++;
                    end
                end
                dq_pkg::CMD_POP_BACK: begin
                    if (fill == 0) begin
                        o.status = dq_pkg::ST_EMPTY;
                    end else begin
                        fill--;
                        o.value = slots[slot_ix(head + fill)];
                    end
                end
                dq_pkg::CMD_POP_FRONT: begin
                    if (fill == 0) begin
                        o.status = dq_pkg::ST_EMPTY;
                    end else begin
                        o.value = slots[slot_ix(head)];
                        head = (head + 1) % DQ_DEPTH;
                        fill--;
                    end
                end
                dq_pkg::CMD_READ: begin
                    p = (pos == 0) ? 1 : pos;
                    if (fill == 0)
                        o.status = dq_pkg::ST_EMPTY;
                    else if (p > fill)
                        o.status = dq_pkg::ST_RANGE;
                    else
                        o.value = slots[slot_ix(head + p - 1)];
                end
                dq_pkg::CMD_FIND: begin
                    for (int i = 0; i < fill && o.found == 0; i++)
                        if (slots[slot_ix(head + i)] == value)
                            o.found = dq_pkg::POS_W'(i + 1);
                end
                default: ;
            endcase
            o.count = dq_pkg::CNT_W'(fill);
            pending.push_back(o);
        endfunction

        function void check_result(logic [47:0] word);
            dq_outcome_t o;
            logic [dq_pkg::DATA_W-1:0] got_value;
            logic [dq_pkg::POS_W-1:0]  got_found;
            dq_pkg::status_t           got_status;
            logic [dq_pkg::CNT_W-1:0]  got_count;
            got_value  = word[31:0];
            got_found  = word[38:32];
            got_status = dq_pkg::status_t'(word[40:39]);
            got_count  = word[47:41];
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: value=%h found=%0d status=%0d count=%0d",
                             $realtime, got_value, got_found, got_status, got_count);
                return;
            end
            o = pending.pop_front();
            if (o.value !== got_value || o.found !== got_found ||
                o.status !== got_status || o.count !== got_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] mismatch: exp value=%h found=%0d status=%0d count=%0d",
                             $realtime, o.value, o.found, o.status, o.count,
                             " / got value=%h found=%0d status=%0d count=%0d",
                             got_value, got_found, got_status, got_count);
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // data_value[31:0], position[38:32], pad[39]
    logic [2:0]  s_tuser  = '0;   // command[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [47:0] m_tdata;         // result_value[31:0], found_position[38:32],
                                  // status[40:39], element_count[47:41]

    deque_mirror sb = new();
    bit          steady      = 1'b0;
    bit          hold_output = 1'b0;
    int          stall_cycles = 0;

    double_ended_queue i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_command(s_tuser, s_tdata[31:0], s_tdata[38:32]);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // output side: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_output = 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 13);
            end
        end
    end

    task automatic send(logic [dq_pkg::CMD_W-1:0] cmd, logic [dq_pkg::DATA_W-1:0] value,
                        logic [dq_pkg::POS_W-1:0] pos);
        if (!steady)
            while ($urandom_range(99) < 13) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pos, value};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending.size() != 0);
    endtask

    function automatic logic [dq_pkg::DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return $urandom;
        if (r < 70)
            return $urandom_range(7);
        if (r < 85) begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'hffff_ffff;
                default: return 32'h0;
            endcase
        end
        return sb.stored_value();
    endfunction

    task automatic random_command(int unsigned push_pct);
        int unsigned r;
        int unsigned top;
        logic [dq_pkg::POS_W-1:0] pos;
        pos = dq_pkg::POS_W'($urandom_range(64));
        if ($urandom_range(99) < push_pct) begin
            send($urandom_range(1) ? dq_pkg::CMD_PUSH_BACK : dq_pkg::CMD_PUSH_FRONT,
                 pick_value(), pos);
            return;
        end
        r = $urandom_range(99);
        if (r < 50) begin
            send($urandom_range(1) ? dq_pkg::CMD_POP_BACK : dq_pkg::CMD_POP_FRONT,
                 $urandom, pos);
        end else if (r < 70) begin
            top = (sb.fill + 1 > 64) ? 64 : sb.fill + 1;
            if ($urandom_range(3) != 0)
                pos = dq_pkg::POS_W'($urandom_range(top));
            send(dq_pkg::CMD_READ, $urandom, pos);
        end else if (r < 95) begin
            send(dq_pkg::CMD_FIND,
                 ($urandom_range(99) < 60) ? sb.stored_value() : pick_value(), pos);
        end else begin
            send($urandom_range(1) ? CMD_SPARE_LO : CMD_SPARE_HI, $urandom, pos);
        end
    endtask

    initial begin
        int unsigned bias [15];
        bias = '{85, 50, 90, 15, 60, 40, 85, 70, 10, 55, 90, 50, 20, 65, 45};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // empty queue corners
        send(dq_pkg::CMD_POP_BACK,   32'h1234_5678, 7'd0);
        send(dq_pkg::CMD_POP_FRONT,  32'hffff_ffff, 7'd64);
        send(dq_pkg::CMD_READ,       32'h0,         7'd0);
        send(dq_pkg::CMD_FIND,       32'h0,         7'd1);
        send(CMD_SPARE_LO,           32'hffff_ffff, 7'd127);
        send(CMD_SPARE_HI,           32'h0,         7'd0);
        // contents: 0x80000000, 0x7fffffff, 0xffffffff, 0x00000000
        send(dq_pkg::CMD_PUSH_BACK,  32'h7fff_ffff, 7'd0);
        send(dq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 7'd0);
        send(dq_pkg::CMD_PUSH_BACK,  32'hffff_ffff, 7'd0);
        send(dq_pkg::CMD_PUSH_BACK,  32'h0,         7'd0);
        send(dq_pkg::CMD_READ,       32'h0,         7'd0);
        send(dq_pkg::CMD_READ,       32'h0,         7'd1);
        send(dq_pkg::CMD_READ,       32'h0,         7'd4);
        send(dq_pkg::CMD_READ,       32'h0,         7'd5);
        send(dq_pkg::CMD_READ,       32'h0,         7'd64);
        send(dq_pkg::CMD_FIND,       32'h8000_0000, 7'd0);
        send(dq_pkg::CMD_FIND,       32'hffff_ffff, 7'd0);
        send(dq_pkg::CMD_FIND,       32'h0,         7'd0);
        send(dq_pkg::CMD_FIND,       32'h0001_2345, 7'd0);
        send(CMD_SPARE_LO,           32'h5555_aaaa, 7'd3);
        send(dq_pkg::CMD_POP_FRONT,  32'h0,         7'd0);
        send(dq_pkg::CMD_POP_BACK,   32'h0,         7'd0);
        send(dq_pkg::CMD_PUSH_FRONT, 32'h0000_0001, 7'd0);
        send(dq_pkg::CMD_FIND,       32'h7fff_ffff, 7'd0);

        for (int ph = 0; ph < 15; ph++) begin
            if (ph == 2)
                hold_output = 1'b1;
            if (ph == 4)
                steady = 1'b1;
            if (ph == 7)
                wait_for_results();
            for (int n = 0; n < 80; n++)
                random_command(bias[ph]);
            steady = 1'b0;
        end

        wait_for_results();
        repeat (80) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
